@@ hdl/arp_pkg.sv @@
// Shared types, codes and sizes of the ARP cache resolver.
`default_nettype none
package arp_pkg;

    localparam int MAP_ENTRIES  = 16;
    localparam int PEND_ENTRIES = 8;
    localparam int MAP_IDX_W    = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
    localparam int PEND_IDX_W   = (PEND_ENTRIES > 1) ? $clog2(PEND_ENTRIES) : 1;
    localparam int SCAN_CYCLES  = (MAP_ENTRIES > PEND_ENTRIES) ? MAP_ENTRIES : PEND_ENTRIES;
    localparam int SCAN_CNT_W   = $clog2(SCAN_CYCLES + 1);

    localparam int MAC_W      = 48;
    localparam int IP_W       = 32;
    localparam int ELAPSED_W  = 16;
    localparam int MAP_AGE_W  = 15;
    localparam int PEND_AGE_W = 13;

    localparam logic [MAC_W-1:0]      MAC_BROADCAST    = '1;
    localparam logic [PEND_AGE_W-1:0] REQ_HOLD_RESET   = 13'd5000;
    localparam logic [MAP_AGE_W-1:0]  LIFETIME_RESET   = 15'd30000;
    localparam logic [MAP_AGE_W-1:0]  MAP_AGE_MAX      = '1;
    localparam logic [PEND_AGE_W-1:0] PEND_AGE_MAX     = '1;

    typedef enum logic [1:0] {
        CMD_SEND = 2'd0,
        CMD_RX   = 2'd1,
        CMD_TICK = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_IPV4  = 2'd0,
        KIND_ARP   = 2'd1,
        KIND_OTHER = 2'd2,
        KIND_RSVD  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ACT_NONE   = 3'd0,
        ACT_SEND   = 3'd1,
        ACT_BCAST  = 3'd2,
        ACT_REPLY  = 3'd3,
        ACT_ACCEPT = 3'd4
    } act_t;

    typedef enum logic [1:0] {
        CFG_OWN_MAC  = 2'd0,
        CFG_OWN_IP   = 2'd1,
        CFG_REQ_HOLD = 2'd2,
        CFG_LIFETIME = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EVAL = 2'd1,
        ST_SCAN = 2'd2
    } state_t;

    typedef struct packed {
        logic                 tick;
        logic [ELAPSED_W-1:0] elapsed;
        logic [MAP_AGE_W-1:0] limit;
        logic                 wr;
        logic [IP_W-1:0]      ip;
        logic [MAC_W-1:0]     mac;
    } map_ctrl_t;

    typedef struct packed {
        logic                  tick;
        logic [ELAPSED_W-1:0]  elapsed;
        logic [PEND_AGE_W-1:0] limit;
        logic                  wr;
        logic [IP_W-1:0]       ip;
    } pend_ctrl_t;

    typedef struct packed {
        logic                 vld;
        logic [MAP_AGE_W-1:0] age;
        logic [MAP_IDX_W-1:0] idx;
    } map_cand_t;

    typedef struct packed {
        logic                  vld;
        logic [PEND_AGE_W-1:0] age;
        logic [PEND_IDX_W-1:0] idx;
    } pend_cand_t;

endpackage
`default_nettype wire

@@ hdl/arp_map_cell.sv @@
// One entry of the IP-to-MAC cache with its aging and oldest-entry chain stage.
`default_nettype none
module arp_map_cell (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire arp_pkg::map_ctrl_t            ctrl,
    input  wire logic                          sel,
    input  wire logic [arp_pkg::MAP_IDX_W-1:0] my_idx,
    input  wire arp_pkg::map_cand_t            cand_in,
    output arp_pkg::map_cand_t                 cand_out,
    output logic                               valid,
    output logic                               hit,
    output logic [arp_pkg::MAC_W-1:0]          mac
);

    logic                            valid_reg;
    logic [arp_pkg::IP_W-1:0]        ip_reg;
    logic [arp_pkg::MAC_W-1:0]       mac_reg;
    logic [arp_pkg::MAP_AGE_W-1:0]   age_reg;
    logic [arp_pkg::MAP_AGE_W-1:0]   age_next;
    logic [arp_pkg::ELAPSED_W:0]     sum;
    arp_pkg::map_cand_t              cand_reg;
    arp_pkg::map_cand_t              cand_next;

    always_comb
    begin
        sum = {{(arp_pkg::ELAPSED_W + 1 - arp_pkg::MAP_AGE_W){1'b0}}, age_reg}
            + {1'b0, ctrl.elapsed};
        if (sum > {{(arp_pkg::ELAPSED_W + 1 - arp_pkg::MAP_AGE_W){1'b0}}, arp_pkg::MAP_AGE_MAX})
        begin
            age_next = arp_pkg::MAP_AGE_MAX;
        end
        else
        begin
            age_next = sum[arp_pkg::MAP_AGE_W-1:0];
        end
    end

    always_comb
    begin
        if (valid_reg && (!cand_in.vld || age_reg > cand_in.age))
        begin
            cand_next.vld = 1'b1;
            cand_next.age = age_reg;
            cand_next.idx = my_idx;
        end
        else
        begin
            cand_next = cand_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cand_reg  <= '0;
        end
        else
        begin
            cand_reg <= cand_next;
            if (sel && ctrl.wr)
            begin
                valid_reg <= 1'b1;
            end
            else if (ctrl.tick && valid_reg && age_next >= ctrl.limit)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sel && ctrl.wr)
        begin
            ip_reg  <= ctrl.ip;
            mac_reg <= ctrl.mac;
            age_reg <= '0;
        end
        else if (ctrl.tick && valid_reg)
        begin
            age_reg <= age_next;
        end
    end

    assign cand_out = cand_reg;
    assign valid    = valid_reg;
    assign hit      = valid_reg && (ip_reg == ctrl.ip);
    assign mac      = mac_reg;

endmodule
`default_nettype wire

@@ hdl/arp_pend_cell.sv @@
// One entry of the pending request table with its aging and oldest-entry chain stage.
`default_nettype none
module arp_pend_cell (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire arp_pkg::pend_ctrl_t            ctrl,
    input  wire logic                           sel,
    input  wire logic [arp_pkg::PEND_IDX_W-1:0] my_idx,
    input  wire arp_pkg::pend_cand_t            cand_in,
    output arp_pkg::pend_cand_t                 cand_out,
    output logic                                valid,
    output logic                                hit
);

    logic                            valid_reg;
    logic [arp_pkg::IP_W-1:0]        ip_reg;
    logic [arp_pkg::PEND_AGE_W-1:0]  age_reg;
    logic [arp_pkg::PEND_AGE_W-1:0]  age_next;
    logic [arp_pkg::ELAPSED_W:0]     sum;
    arp_pkg::pend_cand_t             cand_reg;
    arp_pkg::pend_cand_t             cand_next;

    always_comb
    begin
        sum = {{(arp_pkg::ELAPSED_W + 1 - arp_pkg::PEND_AGE_W){1'b0}}, age_reg}
            + {1'b0, ctrl.elapsed};
        if (sum > {{(arp_pkg::ELAPSED_W + 1 - arp_pkg::PEND_AGE_W){1'b0}},
                   arp_pkg::PEND_AGE_MAX})
        begin
            age_next = arp_pkg::PEND_AGE_MAX;
        end
        else
        begin
            age_next = sum[arp_pkg::PEND_AGE_W-1:0];
        end
    end

    always_comb
    begin
        if (valid_reg && (!cand_in.vld || age_reg > cand_in.age))
        begin
            cand_next.vld = 1'b1;
            cand_next.age = age_reg;
            cand_next.idx = my_idx;
        end
        else
        begin
            cand_next = cand_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cand_reg  <= '0;
        end
        else
        begin
            cand_reg <= cand_next;
            if (sel && ctrl.wr)
            begin
                valid_reg <= 1'b1;
            end
            else if (ctrl.tick && valid_reg && age_next >= ctrl.limit)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sel && ctrl.wr)
        begin
            ip_reg  <= ctrl.ip;
            age_reg <= '0;
        end
        else if (ctrl.tick && valid_reg)
        begin
            age_reg <= age_next;
        end
    end

    assign cand_out = cand_reg;
    assign valid    = valid_reg;
    assign hit      = valid_reg && (ip_reg == ctrl.ip);

endmodule
`default_nettype wire

@@ hdl/arp_cache_resolver.sv @@
// Top level of the ARP cache resolver: item sequencer, configuration and cell rows.
// Flow: an accepted item is captured in the input registers, decided in the evaluate state
// and loaded into the output register once the output is free; a full table that must give up
// its oldest entry adds the scan state first. The input stalls until the item is committed.
// Reset: all entries invalid, own address 0, hold 5000 ms and lifetime 30000 ms.
`default_nettype none
module arp_cache_resolver (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [47:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  command,
    input  wire logic [31:0] next_hop_ip,
    input  wire logic [15:0] elapsed_ms,
    input  wire logic [47:0] dest_mac_in,
    input  wire logic [1:0]  frame_kind,
    input  wire logic        arp_ok,
    input  wire logic        arp_is_request,
    input  wire logic [31:0] sender_ip,
    input  wire logic [47:0] sender_mac,
    input  wire logic [31:0] target_ip,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       action,
    output logic [47:0]      out_mac,
    output logic [31:0]      out_ip
);

    localparam int NM = arp_pkg::MAP_ENTRIES;
    localparam int NP = arp_pkg::PEND_ENTRIES;

    logic [47:0] own_mac_reg;
    logic [31:0] own_ip_reg;
    logic [12:0] req_hold_reg;
    logic [14:0] lifetime_reg;

    arp_pkg::cmd_t  cmd_reg;
    arp_pkg::kind_t kind_reg;
    logic [31:0] hop_reg;
    logic [15:0] elapsed_reg;
    logic [47:0] dst_reg;
    logic        arp_ok_reg;
    logic        is_req_reg;
    logic [31:0] s_ip_reg;
    logic [47:0] s_mac_reg;
    logic [31:0] t_ip_reg;

    arp_pkg::state_t state_reg, state_next;
    logic [arp_pkg::SCAN_CNT_W-1:0] cnt_reg;
    logic scan_done_reg;

    logic        out_valid_reg;
    arp_pkg::act_t act_reg;
    logic [47:0] out_mac_reg;
    logic [31:0] out_ip_reg;

    arp_pkg::map_ctrl_t  map_ctrl;
    arp_pkg::pend_ctrl_t pend_ctrl;
    arp_pkg::map_cand_t  map_cand [0:NM];
    arp_pkg::pend_cand_t pend_cand [0:NP];
    logic [NM-1:0] map_valid, map_hit, map_hit_oh, map_free_oh, map_vict_oh, map_sel;
    logic [NP-1:0] pend_valid, pend_hit, pend_free_oh, pend_vict_oh, pend_sel;
    logic [47:0] map_mac [0:NM-1];
    logic [47:0] hit_mac;

    logic in_xfer, out_free, dst_ok, learn, send_new;
    logic map_need_vict, pend_need_vict, wait_scan, commit, do_tick;
    arp_pkg::act_t act_c;
    logic [47:0] mac_c;
    logic [31:0] ip_c;
    logic seen_hit, seen_mfree, seen_pfree;

    assign in_xfer  = in_valid && !in_stall;
    assign in_stall = (state_reg != arp_pkg::ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_mac_reg  <= '0;
            own_ip_reg   <= '0;
            req_hold_reg <= arp_pkg::REQ_HOLD_RESET;
            lifetime_reg <= arp_pkg::LIFETIME_RESET;
        end
        else if (cfg_we)
        begin
            case (arp_pkg::cfg_idx_t'(cfg_index))
                arp_pkg::CFG_OWN_MAC:  own_mac_reg  <= cfg_data;
                arp_pkg::CFG_OWN_IP:   own_ip_reg   <= cfg_data[31:0];
                arp_pkg::CFG_REQ_HOLD: req_hold_reg <= cfg_data[12:0];
                arp_pkg::CFG_LIFETIME: lifetime_reg <= cfg_data[14:0];
                default:               lifetime_reg <= lifetime_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            cmd_reg     <= arp_pkg::cmd_t'(command);
            kind_reg    <= arp_pkg::kind_t'(frame_kind);
            hop_reg     <= next_hop_ip;
            elapsed_reg <= elapsed_ms;
            dst_reg     <= dest_mac_in;
            arp_ok_reg  <= arp_ok;
            is_req_reg  <= arp_is_request;
            s_ip_reg    <= sender_ip;
            s_mac_reg   <= sender_mac;
            t_ip_reg    <= target_ip;
        end
    end

    assign map_cand[0]  = '0;
    assign pend_cand[0] = '0;

    for (genvar g = 0; g < NM; g++)
    begin : g_map
        arp_map_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (map_ctrl),
            .sel      (map_sel[g]),
            .my_idx   (arp_pkg::MAP_IDX_W'(g)),
            .cand_in  (map_cand[g]),
            .cand_out (map_cand[g+1]),
            .valid    (map_valid[g]),
            .hit      (map_hit[g]),
            .mac      (map_mac[g])
        );
    end

    for (genvar g = 0; g < NP; g++)
    begin : g_pend
        arp_pend_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (pend_ctrl),
            .sel      (pend_sel[g]),
            .my_idx   (arp_pkg::PEND_IDX_W'(g)),
            .cand_in  (pend_cand[g]),
            .cand_out (pend_cand[g+1]),
            .valid    (pend_valid[g]),
            .hit      (pend_hit[g])
        );
    end

    always_comb
    begin
        seen_hit   = 1'b0;
        seen_mfree = 1'b0;
        hit_mac    = '0;
        for (int i = 0; i < NM; i++)
        begin
            map_hit_oh[i]  = map_hit[i] && !seen_hit;
            seen_hit       = seen_hit || map_hit[i];
            map_free_oh[i] = !map_valid[i] && !seen_mfree;
            seen_mfree     = seen_mfree || !map_valid[i];
            map_vict_oh[i] = (map_cand[NM].idx == arp_pkg::MAP_IDX_W'(i));
            if (map_hit_oh[i])
            begin
                hit_mac = hit_mac | map_mac[i];
            end
        end
        seen_pfree = 1'b0;
        for (int i = 0; i < NP; i++)
        begin
            pend_free_oh[i] = !pend_valid[i] && !seen_pfree;
            seen_pfree      = seen_pfree || !pend_valid[i];
            pend_vict_oh[i] = (pend_cand[NP].idx == arp_pkg::PEND_IDX_W'(i));
        end
    end

    assign dst_ok = (dst_reg == arp_pkg::MAC_BROADCAST) || (dst_reg == own_mac_reg);
    assign learn  = (cmd_reg == arp_pkg::CMD_RX) && dst_ok
                 && (kind_reg == arp_pkg::KIND_ARP) && arp_ok_reg;
    assign send_new = (cmd_reg == arp_pkg::CMD_SEND) && !(|map_hit) && !(|pend_hit);
    assign map_need_vict  = learn && !(|map_hit) && (&map_valid);
    assign pend_need_vict = send_new && (&pend_valid);
    assign wait_scan = (map_need_vict || pend_need_vict) && !scan_done_reg;

    // Decision, output values and cell write controls of the evaluate step.
    always_comb
    begin
        commit  = (state_reg == arp_pkg::ST_EVAL) && !wait_scan && out_free;
        do_tick = commit && (cmd_reg == arp_pkg::CMD_TICK);
        act_c   = arp_pkg::ACT_NONE;
        mac_c   = '0;
        ip_c    = '0;
        case (cmd_reg)
            arp_pkg::CMD_SEND:
            begin
                if (|map_hit)
                begin
                    act_c = arp_pkg::ACT_SEND;
                    mac_c = hit_mac;
                    ip_c  = hop_reg;
                end
                else if (send_new)
                begin
                    act_c = arp_pkg::ACT_BCAST;
                    mac_c = arp_pkg::MAC_BROADCAST;
                    ip_c  = hop_reg;
                end
            end
            arp_pkg::CMD_RX:
            begin
                if (dst_ok && kind_reg == arp_pkg::KIND_IPV4)
                begin
                    act_c = arp_pkg::ACT_ACCEPT;
                end
                else if (learn && is_req_reg && t_ip_reg == own_ip_reg)
                begin
                    act_c = arp_pkg::ACT_REPLY;
                    mac_c = s_mac_reg;
                    ip_c  = s_ip_reg;
                end
            end
            default:
            begin
                act_c = arp_pkg::ACT_NONE;
            end
        endcase

        map_ctrl.tick    = do_tick;
        map_ctrl.elapsed = elapsed_reg;
        map_ctrl.limit   = lifetime_reg;
        map_ctrl.wr      = commit && learn;
        map_ctrl.ip      = (cmd_reg == arp_pkg::CMD_SEND) ? hop_reg : s_ip_reg;
        map_ctrl.mac     = s_mac_reg;
        pend_ctrl.tick    = do_tick;
        pend_ctrl.elapsed = elapsed_reg;
        pend_ctrl.limit   = req_hold_reg;
        pend_ctrl.wr      = commit && send_new;
        pend_ctrl.ip      = hop_reg;

        if (!map_ctrl.wr)
        begin
            map_sel = '0;
        end
        else if (|map_hit)
        begin
            map_sel = map_hit_oh;
        end
        else if (!(&map_valid))
        begin
            map_sel = map_free_oh;
        end
        else
        begin
            map_sel = map_vict_oh;
        end

        if (!pend_ctrl.wr)
        begin
            pend_sel = '0;
        end
        else if (!(&pend_valid))
        begin
            pend_sel = pend_free_oh;
        end
        else
        begin
            pend_sel = pend_vict_oh;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            arp_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = arp_pkg::ST_EVAL;
                end
            end
            arp_pkg::ST_EVAL:
            begin
                if (wait_scan)
                begin
                    state_next = arp_pkg::ST_SCAN;
                end
                else if (commit)
                begin
                    state_next = arp_pkg::ST_IDLE;
                end
            end
            arp_pkg::ST_SCAN:
            begin
                if (cnt_reg == arp_pkg::SCAN_CNT_W'(arp_pkg::SCAN_CYCLES - 1))
                begin
                    state_next = arp_pkg::ST_EVAL;
                end
            end
            default:
            begin
                state_next = arp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= arp_pkg::ST_IDLE;
            cnt_reg       <= '0;
            scan_done_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == arp_pkg::ST_SCAN)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else
            begin
                cnt_reg <= '0;
            end
            if (state_reg == arp_pkg::ST_SCAN)
            begin
                scan_done_reg <= 1'b1;
            end
            else if (commit)
            begin
                scan_done_reg <= 1'b0;
            end
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            act_reg     <= act_c;
            out_mac_reg <= mac_c;
            out_ip_reg  <= ip_c;
        end
    end

    assign out_valid = out_valid_reg;
    assign action    = act_reg;
    assign out_mac   = out_mac_reg;
    assign out_ip    = out_ip_reg;

`ifndef SYNTHESIS
    a_map_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(map_sel))
        else $error("more than one cache entry written");
    a_pend_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(pend_sel))
        else $error("more than one pending entry written");
    a_accept_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> state_reg == arp_pkg::ST_EVAL)
        else $error("accepted item not evaluated");
    a_result_from_eval: assert property (@(posedge clk) disable iff (!rst_n)
        commit |-> state_reg == arp_pkg::ST_EVAL && out_free)
        else $error("result loaded outside evaluation");
`endif

endmodule
`default_nettype wire

@@ sim/arp_resolver_checker.sv @@
// Checker for the ARP cache resolver: predicts each result and compares it with the block.
`timescale 1ns / 1ps
module arp_resolver_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [47:0] cfg_data,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [1:0]  command,
    input  wire logic [31:0] next_hop_ip,
    input  wire logic [15:0] elapsed_ms,
    input  wire logic [47:0] dest_mac_in,
    input  wire logic [1:0]  frame_kind,
    input  wire logic        arp_ok,
    input  wire logic        arp_is_request,
    input  wire logic [31:0] sender_ip,
    input  wire logic [47:0] sender_mac,
    input  wire logic [31:0] target_ip,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [2:0]  action,
    input  wire logic [47:0] out_mac,
    input  wire logic [31:0] out_ip,
    output int               errors,
    output int               pending_results
);

    typedef struct packed {
        logic [2:0]  act;
        logic [47:0] mac;
        logic [31:0] ip;
    } arp_result_t;

    arp_result_t exp_fifo [64];
    int          exp_head;
    int          exp_tail;

    logic [47:0] m_own_mac;
    logic [31:0] m_own_ip;
    logic [12:0] m_hold;
    logic [14:0] m_life;
    logic        c_valid [arp_pkg::MAP_ENTRIES];
    logic [31:0] c_ip    [arp_pkg::MAP_ENTRIES];
    logic [47:0] c_mac   [arp_pkg::MAP_ENTRIES];
    logic [14:0] c_age   [arp_pkg::MAP_ENTRIES];
    logic        p_valid [arp_pkg::PEND_ENTRIES];
    logic [31:0] p_ip    [arp_pkg::PEND_ENTRIES];
    logic [12:0] p_age   [arp_pkg::PEND_ENTRIES];

    assign pending_results = exp_tail - exp_head;

    function automatic arp_result_t resolve_item();
        arp_result_t r;
        int slot;
        int sum;
        r = '0;
        slot = -1;
        if (command == arp_pkg::CMD_SEND) begin
            for (int i = arp_pkg::MAP_ENTRIES - 1; i >= 0; i--)
                if (c_valid[i] && c_ip[i] == next_hop_ip) slot = i;
            if (slot >= 0) begin
                r.act = arp_pkg::ACT_SEND;
                r.mac = c_mac[slot];
                r.ip = next_hop_ip;
            end else begin
                for (int i = 0; i < arp_pkg::PEND_ENTRIES; i++)
                    if (p_valid[i] && p_ip[i] == next_hop_ip) slot = i;
                if (slot < 0) begin
                    for (int i = arp_pkg::PEND_ENTRIES - 1; i >= 0; i--)
                        if (!p_valid[i]) slot = i;
                    if (slot < 0) begin
                        slot = 0;
                        for (int i = 1; i < arp_pkg::PEND_ENTRIES; i++)
                            if (p_age[i] > p_age[slot]) slot = i;
                    end
                    p_valid[slot] = 1'b1;
                    p_ip[slot] = next_hop_ip;
                    p_age[slot] = '0;
                    r.act = arp_pkg::ACT_BCAST;
                    r.mac = arp_pkg::MAC_BROADCAST;
                    r.ip = next_hop_ip;
                end
            end
        end else if (command == arp_pkg::CMD_RX) begin
            if (dest_mac_in == arp_pkg::MAC_BROADCAST || dest_mac_in == m_own_mac) begin
                if (frame_kind == arp_pkg::KIND_IPV4) begin
                    r.act = arp_pkg::ACT_ACCEPT;
                end else if (frame_kind == arp_pkg::KIND_ARP && arp_ok) begin
                    for (int i = arp_pkg::MAP_ENTRIES - 1; i >= 0; i--)
                        if (c_valid[i] && c_ip[i] == sender_ip) slot = i;
                    if (slot < 0)
                        for (int i = arp_pkg::MAP_ENTRIES - 1; i >= 0; i--)
                            if (!c_valid[i]) slot = i;
                    if (slot < 0) begin
                        slot = 0;
                        for (int i = 1; i < arp_pkg::MAP_ENTRIES; i++)
                            if (c_age[i] > c_age[slot]) slot = i;
                    end
                    c_valid[slot] = 1'b1;
                    c_ip[slot] = sender_ip;
                    c_mac[slot] = sender_mac;
                    c_age[slot] = '0;
                    if (arp_is_request && target_ip == m_own_ip) begin
                        r.act = arp_pkg::ACT_REPLY;
                        r.mac = sender_mac;
                        r.ip = sender_ip;
                    end
                end
            end
        end else if (command == arp_pkg::CMD_TICK) begin
            for (int i = 0; i < arp_pkg::PEND_ENTRIES; i++) begin
                if (p_valid[i]) begin
                    sum = p_age[i] + elapsed_ms;
                    p_age[i] = (sum > 8191) ? 13'h1fff : sum[12:0];
                    if (p_age[i] >= m_hold) p_valid[i] = 1'b0;
                end
            end
            for (int i = 0; i < arp_pkg::MAP_ENTRIES; i++) begin
                if (c_valid[i]) begin
                    sum = c_age[i] + elapsed_ms;
                    c_age[i] = (sum > 32767) ? 15'h7fff : sum[14:0];
                    if (c_age[i] >= m_life) c_valid[i] = 1'b0;
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        arp_result_t want;
        if (!rst_n) begin
            errors <= 0;
            exp_head = 0;
            exp_tail = 0;
            m_own_mac = '0;
            m_own_ip = '0;
            m_hold = 13'd5000;
            m_life = 15'd30000;
            for (int i = 0; i < arp_pkg::MAP_ENTRIES; i++) c_valid[i] = 1'b0;
            for (int i = 0; i < arp_pkg::PEND_ENTRIES; i++) p_valid[i] = 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    arp_pkg::CFG_OWN_MAC:  m_own_mac = cfg_data;
                    arp_pkg::CFG_OWN_IP:   m_own_ip = cfg_data[31:0];
                    arp_pkg::CFG_REQ_HOLD: m_hold = cfg_data[12:0];
                    arp_pkg::CFG_LIFETIME: m_life = cfg_data[14:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall) begin
                if (exp_tail == exp_head) begin
                    $display("%0t: unexpected result action %0d mac %h ip %h",
                             $time, action, out_mac, out_ip);
                    errors <= errors + 1;
                end else begin
                    want = exp_fifo[exp_head % 64];
                    exp_head = exp_head + 1;
                    if (want.act !== action || want.mac !== out_mac || want.ip !== out_ip) begin
                        $display("%0t: expected action %0d mac %h ip %h, got %0d %h %h",
                                 $time, want.act, want.mac, want.ip, action, out_mac, out_ip);
                        errors <= errors + 1;
                    end
                end
            end
            if (in_valid && !in_stall) begin
                exp_fifo[exp_tail % 64] = resolve_item();
                exp_tail = exp_tail + 1;
            end
        end
    end

endmodule

@@ sim/tb_top.sv @@
// Top of the ARP cache resolver testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [47:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  command;
    logic [31:0] next_hop_ip;
    logic [15:0] elapsed_ms;
    logic [47:0] dest_mac_in;
    logic [1:0]  frame_kind;
    logic        arp_ok;
    logic        arp_is_request;
    logic [31:0] sender_ip;
    logic [47:0] sender_mac;
    logic [31:0] target_ip;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  action;
    logic [47:0] out_mac;
    logic [31:0] out_ip;
    int          errors;
    int          pending_results;
    int          cycle_count;
    logic [47:0] cur_mac;
    logic [31:0] cur_ip;
    logic [31:0] ip_pool [24];

    arp_cache_resolver dut (.*);

    arp_resolver_checker checker_i (.*);

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 1000000) begin
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    initial begin
        out_stall = 1'b0;
        forever begin
            @(posedge clk);
            if ($urandom_range(0, 199) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(10, 40)) @(posedge clk);
                out_stall <= 1'b0;
            end else begin
                out_stall <= ($urandom_range(0, 99) < 30) ? 1'b1 : 1'b0;
            end
        end
    end

    task automatic write_reg(input arp_pkg::cfg_idx_t idx, input logic [47:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == arp_pkg::CFG_OWN_MAC) cur_mac = val;
        if (idx == arp_pkg::CFG_OWN_IP) cur_ip = val[31:0];
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic send_item(input arp_pkg::cmd_t c, input logic [31:0] nh,
                             input logic [15:0] el, input logic [47:0] dm,
                             input arp_pkg::kind_t k, input logic ok,
                             input logic rq, input logic [31:0] sip, input logic [47:0] smac,
                             input logic [31:0] tip);
        int g;
        g = gap_len();
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= c;
        next_hop_ip <= nh;
        elapsed_ms <= el;
        dest_mac_in <= dm;
        frame_kind <= k;
        arp_ok <= ok;
        arp_is_request <= rq;
        sender_ip <= sip;
        sender_mac <= smac;
        target_ip <= tip;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic random_item();
        int r;
        logic [47:0] dm;
        logic [31:0] tip;
        r = $urandom_range(0, 99);
        dm = ($urandom_range(0, 9) < 5) ? arp_pkg::MAC_BROADCAST
             : (($urandom_range(0, 9) < 7) ? cur_mac : 48'({$urandom, $urandom}));
        tip = ($urandom_range(0, 9) < 5) ? cur_ip : ip_pool[$urandom_range(0, 23)];
        if (r < 35)
            send_item(arp_pkg::CMD_SEND, ip_pool[$urandom_range(0, 23)], 16'($urandom),
                      48'({$urandom, $urandom}), arp_pkg::kind_t'($urandom),
                      1'($urandom), 1'($urandom),
                      $urandom, 48'({$urandom, $urandom}), $urandom);
        else if (r < 80)
            send_item(arp_pkg::CMD_RX, $urandom, 16'($urandom), dm,
                      arp_pkg::kind_t'(($urandom_range(0, 9) < 7)
                                       ? arp_pkg::KIND_ARP : $urandom_range(0, 3)),
                      ($urandom_range(0, 9) < 8), 1'($urandom),
                      ip_pool[$urandom_range(0, 23)], 48'({$urandom, $urandom}), tip);
        else if (r < 97)
            send_item(arp_pkg::CMD_TICK, $urandom, ($urandom_range(0, 9) < 8)
                      ? 16'($urandom_range(0, 3000)) : 16'($urandom), dm,
                      arp_pkg::kind_t'($urandom), 1'($urandom), 1'($urandom),
                      $urandom, 48'({$urandom, $urandom}), $urandom);
        else
            send_item(arp_pkg::CMD_NONE, $urandom, 16'($urandom), dm,
                      arp_pkg::kind_t'($urandom), 1'($urandom), 1'($urandom),
                      $urandom, 48'({$urandom, $urandom}), $urandom);
    endtask

    initial begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = arp_pkg::CFG_OWN_MAC;
        cfg_data = '0;
        in_valid = 1'b0;
        command = arp_pkg::CMD_NONE;
        next_hop_ip = '0;
        elapsed_ms = '0;
        dest_mac_in = '0;
        frame_kind = arp_pkg::KIND_IPV4;
        arp_ok = 1'b0;
        arp_is_request = 1'b0;
        sender_ip = '0;
        sender_mac = '0;
        target_ip = '0;
        cur_mac = '0;
        cur_ip = '0;
        for (int i = 0; i < 24; i++) ip_pool[i] = $urandom;
        ip_pool[0] = '0;
        ip_pool[1] = '1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (20) @(posedge clk);

        // Directed: reset defaults first, then each command and corner.
        send_item(arp_pkg::CMD_SEND, 32'h0, 16'h0, '0, arp_pkg::KIND_IPV4,
                  1'b0, 1'b0, '0, '0, '0);
        send_item(arp_pkg::CMD_SEND, 32'h0, 16'h0, '0, arp_pkg::KIND_IPV4,
                  1'b0, 1'b0, '0, '0, '0);
        send_item(arp_pkg::CMD_RX, '0, '0, 48'h0, arp_pkg::KIND_ARP,
                  1'b1, 1'b1, 32'h0, '1, 32'h0);
        send_item(arp_pkg::CMD_SEND, 32'h0, '0, '0, arp_pkg::KIND_IPV4,
                  1'b0, 1'b0, '0, '0, '0);
        send_item(arp_pkg::CMD_RX, '0, '0, '1, arp_pkg::KIND_ARP,
                  1'b1, 1'b0, '1, 48'h123456789abc, '1);
        send_item(arp_pkg::CMD_RX, '0, '0, '1, arp_pkg::KIND_ARP,
                  1'b1, 1'b0, '1, 48'h0, '1);
        send_item(arp_pkg::CMD_SEND, '1, '0, '0, arp_pkg::KIND_IPV4,
                  1'b0, 1'b0, '0, '0, '0);
        send_item(arp_pkg::CMD_RX, '0, '0, '1, arp_pkg::KIND_IPV4,
                  1'b0, 1'b0, '0, '0, '0);
        send_item(arp_pkg::CMD_RX, '0, '0, '1, arp_pkg::KIND_OTHER,
                  1'b1, 1'b1, 32'h5, '1, '0);
        send_item(arp_pkg::CMD_RX, '0, '0, '1, arp_pkg::KIND_RSVD,
                  1'b1, 1'b1, 32'h6, '1, '0);
        send_item(arp_pkg::CMD_RX, '0, '0, '1, arp_pkg::KIND_ARP,
                  1'b0, 1'b1, 32'h7, '1, '0);
        send_item(arp_pkg::CMD_RX, '0, '0, 48'h1, arp_pkg::KIND_IPV4,
                  1'b1, 1'b1, '0, '0, '0);
        send_item(arp_pkg::CMD_NONE, '1, '1, '1, arp_pkg::KIND_ARP,
                  1'b1, 1'b1, '1, '1, '1);
        send_item(arp_pkg::CMD_TICK, '0, 16'd4999, '0, arp_pkg::KIND_IPV4,
                  1'b0, 1'b0, '0, '0, '0);
        send_item(arp_pkg::CMD_SEND, 32'h1234, '0, '0, arp_pkg::KIND_IPV4,
                  1'b0, 1'b0, '0, '0, '0);
        send_item(arp_pkg::CMD_TICK, '0, 16'd1, '0, arp_pkg::KIND_IPV4,
                  1'b0, 1'b0, '0, '0, '0);
        send_item(arp_pkg::CMD_SEND, 32'h1234, '0, '0, arp_pkg::KIND_IPV4,
                  1'b0, 1'b0, '0, '0, '0);
        for (int i = 0; i < 9; i++)
            send_item(arp_pkg::CMD_SEND, 32'hA000 + i, '0, '0, arp_pkg::KIND_IPV4,
                      1'b0, 1'b0, '0, '0, '0);
        for (int i = 0; i < 18; i++)
            send_item(arp_pkg::CMD_RX, '0, '0, '1, arp_pkg::KIND_ARP, 1'b1, 1'b0,
                      32'hB000 + i, 48'({$urandom, $urandom}), '0);
        send_item(arp_pkg::CMD_TICK, '0, '1, '0, arp_pkg::KIND_IPV4,
                  1'b0, 1'b0, '0, '0, '0);
        drain();

        write_reg(arp_pkg::CFG_OWN_MAC, '1);
        write_reg(arp_pkg::CFG_OWN_IP, 48'hffffffff);
        write_reg(arp_pkg::CFG_REQ_HOLD, 48'd1);
        write_reg(arp_pkg::CFG_LIFETIME, 48'd1);
        for (int n = 0; n < 300; n++) random_item();
        drain();

        write_reg(arp_pkg::CFG_REQ_HOLD, 48'd0);
        write_reg(arp_pkg::CFG_LIFETIME, 48'd0);
        write_reg(arp_pkg::CFG_OWN_MAC, 48'h0);
        for (int n = 0; n < 200; n++) random_item();
        drain();

        write_reg(arp_pkg::CFG_REQ_HOLD, 48'd8191);
        write_reg(arp_pkg::CFG_LIFETIME, 48'd32767);
        write_reg(arp_pkg::CFG_OWN_MAC, 48'({$urandom, $urandom}));
        write_reg(arp_pkg::CFG_OWN_IP, {16'h0, ip_pool[5]});
        for (int n = 0; n < 700; n++) random_item();
        drain();

        write_reg(arp_pkg::CFG_REQ_HOLD, 48'($urandom_range(1000, 6000)));
        write_reg(arp_pkg::CFG_LIFETIME, 48'($urandom_range(4000, 20000)));
        write_reg(arp_pkg::CFG_OWN_MAC, 48'({$urandom, $urandom}));
        write_reg(arp_pkg::CFG_OWN_IP, {16'h0, ip_pool[9]});
        for (int n = 0; n < 700; n++) random_item();

        drain();
        if (errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

@@ arp_cache_resolver.f @@
hdl/arp_pkg.sv
hdl/arp_map_cell.sv
hdl/arp_pend_cell.sv
hdl/arp_cache_resolver.sv
sim/arp_resolver_checker.sv
sim/tb_top.sv
